>>> design/tdo_pkg.sv
// Shared constants for the toroidal distance and offset core.
// No dependencies; imported by tdo_sqrt_pipe and the top level.
package tdo_pkg;

    localparam int COORD_BITS_DEF = 12;   // default coordinate width
    localparam int SIZE_BITS      = 13;   // world size register width
    localparam int DIST_BITS      = 16;   // distance output width
    localparam int FRAC_BITS      = 4;    // fraction bits of the distance
    localparam int CFG_ADDR_BITS  = 1;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 13'd4096;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_WORLD_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WORLD_HEIGHT = 1'b1;

endpackage

>>> design/tdo_sqrt_pipe.sv
// Pipelined digit-by-digit integer square root, two root bits per stage,
// with a sideband word carried alongside. Depends on tdo_pkg.
module tdo_sqrt_pipe
    import tdo_pkg::*;
#(
    parameter int RAD_BITS  = 2 * COORD_BITS_DEF + 2 * FRAC_BITS + 1,
    parameter int SIDE_BITS = 2 * (COORD_BITS_DEF + 1)
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [RAD_BITS-1:0]             radicand,
    input  logic [SIDE_BITS-1:0]            side_in,
    output logic                            out_valid,
    output logic [(RAD_BITS+1)/2-1:0]       root,
    output logic [SIDE_BITS-1:0]            side_out
);

    localparam int QB  = (RAD_BITS + 1) / 2;   // root bits
    localparam int RW  = QB + 3;               // remainder width with headroom
    localparam int NST = (QB + 1) / 2;         // stages

    logic [2*QB-1:0]    rad_in    [NST];
    logic [RW-1:0]      rem_in    [NST];
    logic [QB-1:0]      root_in   [NST];
    logic               vld_in    [NST];
    logic [SIDE_BITS-1:0] side_in_s [NST];

    logic [2*QB-1:0]    rad_reg   [NST];
    logic [RW-1:0]      rem_reg   [NST];
    logic [QB-1:0]      root_reg  [NST];
    logic               vld_reg   [NST];
    logic [SIDE_BITS-1:0] side_reg [NST];

    genvar s;
    generate
        for (s = 0; s < NST; s++) begin : g_stage
            logic [2*QB-1:0] rad_next;
            logic [RW-1:0]   rem_next;
            logic [QB-1:0]   root_next;

            if (s == 0) begin : g_first
                assign rad_in[s]    = (2*QB)'(radicand);
                assign rem_in[s]    = '0;
                assign root_in[s]   = '0;
                assign vld_in[s]    = in_valid;
                assign side_in_s[s] = side_in;
            end else begin : g_rest
                assign rad_in[s]    = rad_reg[s-1];
                assign rem_in[s]    = rem_reg[s-1];
                assign root_in[s]   = root_reg[s-1];
                assign vld_in[s]    = vld_reg[s-1];
                assign side_in_s[s] = side_reg[s-1];
            end

            always_comb
            begin
                logic [RW-1:0] r2;
                logic [RW-1:0] trial;
                rad_next  = rad_in[s];
                rem_next  = rem_in[s];
                root_next = root_in[s];
                for (int k = 0; k < 2; k++)
                begin
                    if (2 * s + k < QB)
                    begin
                        r2    = {rem_next[RW-3:0], rad_next[2*QB-1 -: 2]};
                        trial = RW'({root_next, 2'b01});
                        if (r2 >= trial)
                        begin
                            rem_next  = r2 - trial;
                            root_next = {root_next[QB-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next  = r2;
                            root_next = {root_next[QB-2:0], 1'b0};
                        end
                        rad_next = {rad_next[2*QB-3:0], 2'b00};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[s] <= vld_in[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[s]  <= rad_next;
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                    side_reg[s] <= side_in_s[s];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NST-1];
    assign root      = root_reg[NST-1];
    assign side_out  = side_reg[NST-1];

endmodule

>>> design/toroidal_distance_and_offset_core.sv
// Toroidal distance and offset core: wrap-around offsets and Euclidean distance.
// Depends on tdo_pkg and tdo_sqrt_pipe.
//
// Usage
//   s_tdata carries one query word: from_x, from_y, to_x, to_y (lowest first).
//   m_tdata returns offset_x, offset_y (two's complement) and distance_q4,
//   the floor of 16 * sqrt(offset_x^2 + offset_y^2), saturated at 65535.
//   World width and height are written on the cfg port (index 0 and 1) while
//   the core is idle; both reset to 4096.
// Timing
//   Three arithmetic stages (wrap, square, sum), then the square root pipe
//   at two root bits per stage, ceil((COORD_BITS+5)/2) stages, then the
//   output register. One word per cycle is accepted and delivered in steady
//   state while the receiver keeps m_tready high.
// Reset and stall
//   Reset empties the pipe (valid bits cleared) and restores the world size.
//   When the receiver holds m_tready low with a word pending, the whole pipe
//   freezes and s_tready drops in the same cycle; nothing is lost or repeated.
module toroidal_distance_and_offset_core
    import tdo_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]         cfg_addr,
    input  logic [SIZE_BITS-1:0]             cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // from_x, from_y, to_x, to_y, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // offset_x, offset_y, distance_q4, zero pad
    output logic [((2*(COORD_BITS+1)+DIST_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int C       = COORD_BITS;
    localparam int OB      = C + 1;                          // offset width
    localparam int WW      = (C + 3 > SIZE_BITS + 3) ? C + 3 : SIZE_BITS + 3;
    localparam int SQB     = 2 * C;                          // square width
    localparam int SUMB    = 2 * C + 1;
    localparam int RADB    = SUMB + 2 * FRAC_BITS;
    localparam int QB      = (RADB + 1) / 2;
    localparam int OUT_W   = ((2 * OB + DIST_BITS + 7) / 8) * 8;

    // configuration registers
    logic [SIZE_BITS-1:0] world_width_reg;
    logic [SIZE_BITS-1:0] world_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_width_reg  <= SIZE_RESET;
            world_height_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_WORLD_WIDTH:  world_width_reg  <= cfg_wdata;
                REG_WORLD_HEIGHT: world_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // global advance: the pipe moves whenever the output slot is free or taken
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: wrapped offsets ----------------
    logic [C-1:0]         from_c [2];
    logic [C-1:0]         to_c   [2];
    logic [SIZE_BITS-1:0] size_c [2];
    logic [OB-1:0]        off_next [2];
    logic [OB-1:0]        off1_reg [2];
    logic                 v1_reg;

    assign from_c[0] = s_tdata[C-1:0];
    assign from_c[1] = s_tdata[2*C-1:C];
    assign to_c[0]   = s_tdata[3*C-1:2*C];
    assign to_c[1]   = s_tdata[4*C-1:3*C];
    assign size_c[0] = world_width_reg;
    assign size_c[1] = world_height_reg;

    always_comb
    begin
        logic signed [WW-1:0] d;
        logic signed [WW-1:0] sz;
        logic signed [WW-1:0] o;
        for (int a = 0; a < 2; a++)
        begin
            d  = $signed(WW'(to_c[a])) - $signed(WW'(from_c[a]));
            sz = $signed(WW'(size_c[a]));
            o  = d;
            if (d > 0)
            begin
                // crossing the edge is strictly shorter
                if ((d <<< 1) > sz)
                    o = d - sz;
            end
            else
            begin
                if (-(d <<< 1) > sz)
                    o = d + sz;
            end
            off_next[a] = o[OB-1:0];
        end
    end

    // ---------------- stage 2: magnitudes squared ----------------
    logic [SQB-1:0] sq_next  [2];
    logic [SQB-1:0] sq2_reg  [2];
    logic [OB-1:0]  off2_reg [2];
    logic           v2_reg;

    always_comb
    begin
        logic [OB-1:0] neg;
        logic [C-1:0]  mag;
        for (int a = 0; a < 2; a++)
        begin
            neg = -off1_reg[a];
            mag = off1_reg[a][OB-1] ? neg[C-1:0] : off1_reg[a][C-1:0];
            sq_next[a] = SQB'(mag) * SQB'(mag);
        end
    end

    // ---------------- stage 3: sum of squares ----------------
    logic [SUMB-1:0] sum3_reg;
    logic [OB-1:0]   off3_reg [2];
    logic            v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off1_reg <= off_next;
            sq2_reg  <= sq_next;
            off2_reg <= off1_reg;
            sum3_reg <= SUMB'(sq2_reg[0]) + SUMB'(sq2_reg[1]);
            off3_reg <= off2_reg;
        end
    end

    // ---------------- square root of 256 * sum ----------------
    logic            sq_valid;
    logic [QB-1:0]   sq_root;
    logic [2*OB-1:0] sq_side;

    tdo_sqrt_pipe #(
        .RAD_BITS  (RADB),
        .SIDE_BITS (2 * OB)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .radicand  ({sum3_reg, {(2*FRAC_BITS){1'b0}}}),
        .side_in   ({off3_reg[1], off3_reg[0]}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // saturate the root to the distance width
    logic [DIST_BITS-1:0] dist_sat;
    generate
        if (QB > DIST_BITS) begin : g_sat
            assign dist_sat = (|sq_root[QB-1:DIST_BITS]) ? '1 : sq_root[DIST_BITS-1:0];
        end else begin : g_ext
            assign dist_sat = DIST_BITS'(sq_root);
        end
    endgenerate

    // ---------------- output register ----------------
    logic [OUT_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= OUT_W'({dist_sat, sq_side});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for toroidal_distance_and_offset_core: wrapped offsets and q4 distance.
// Depends on tdo_pkg and the core RTL; it predicts every result word internally and needs no files.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tdo_pkg::*;

    localparam int CB          = 12;                                   // coordinate width
    localparam int IN_W        = ((4 * CB + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * (CB + 1) + DIST_BITS + 7) / 8) * 8;
    localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all before giving up
    localparam int HOLD_CYCLES = 80;    // long output stall, well beyond the pipe depth
    localparam int DRAIN_TAIL  = 30;    // beyond the pipe depth, catches stray words

    typedef struct packed {
        logic signed [CB:0]      offset_x;
        logic signed [CB:0]      offset_y;
        logic [DIST_BITS-1:0]    distance_q4;
    } answer_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr = '0;
    logic [SIZE_BITS-1:0]      cfg_wdata = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_W-1:0]           s_tdata = '0;    // from_x, from_y, to_x, to_y
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_W-1:0]          m_tdata;         // offset_x, offset_y, distance_q4, pad

    // local copy of the world size registers, follows every cfg write
    logic [SIZE_BITS-1:0]      world_w = SIZE_RESET;
    logic [SIZE_BITS-1:0]      world_h = SIZE_RESET;

    answer_t                   pending_answers[$];
    int unsigned               n_errors = 0;
    int unsigned               n_queries = 0;
    int unsigned               n_results = 0;
    int unsigned               n_worlds = 0;
    int unsigned               quiet_cycles = 0;

    // idling controls; the sink process owns its counters
    bit                        src_idle_en = 1'b1;
    bit                        sink_idle_en = 1'b1;
    bit                        hold_req = 1'b0;

    toroidal_distance_and_offset_core #(.COORD_BITS(CB)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Shortest offset along one axis. Ties (exactly half the size) keep the
    // sign of the raw difference since only a strictly shorter path wraps.
    // Out-of-range coordinates and size zero go through the same rule.
    function automatic logic signed [CB:0] wrap_axis(logic [CB-1:0] from_c,
                                                     logic [CB-1:0] to_c,
                                                     logic [SIZE_BITS-1:0] size);
        int d;
        int s;
        d = int'(to_c) - int'(from_c);
        s = int'(size);
        if (d > 0)
        begin
            if (d > s - d)
                d = d - s;
        end
        else if (-d > s + d)
        begin
            d = d + s;
        end
        return d[CB:0];
    endfunction

    // floor(16 * sqrt(ox^2 + oy^2)), built bit by bit from the top, saturated
    function automatic logic [DIST_BITS-1:0] q4_length(logic signed [CB:0] ox,
                                                       logic signed [CB:0] oy);
        longint sx;
        longint sy;
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned trial;
        sx = longint'(ox);
        sy = longint'(oy);
        if (sx < 0)
            sx = -sx;
        if (sy < 0)
            sy = -sy;
        radicand = (sx * sx + sy * sy) * 256;
        root = 0;
        for (int b = 18; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        if (root > 65535)
            root = 65535;
        return root[DIST_BITS-1:0];
    endfunction

    function automatic answer_t predict_answer(logic [CB-1:0] fx, logic [CB-1:0] fy,
                                               logic [CB-1:0] tx, logic [CB-1:0] ty);
        answer_t a;
        a.offset_x    = wrap_axis(fx, tx, world_w);
        a.offset_y    = wrap_axis(fy, ty, world_h);
        a.distance_q4 = q4_length(a.offset_x, a.offset_y);
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Idling: mostly no gap, some short ones, a few long
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // coordinate below size, biased toward both ends of the range
    function automatic logic [CB-1:0] rand_coord(int unsigned size);
        int unsigned top;
        int unsigned r;
        top = (size == 0) ? 0 : size - 1;
        if (top > (1 << CB) - 1)
            top = (1 << CB) - 1;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return top[CB-1:0];
        r = $urandom_range(0, top);
        return r[CB-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Sink: random stalls, plus a long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned sink_wait;
        int unsigned hold_left;
        sink_wait = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (sink_wait > 0)
            begin
                m_tready <= 1'b0;
                sink_wait--;
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                sink_wait = pick_gap();
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking: each output word against the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR result %0d %s: got %0d, expected %0d", n_results, what, got, want);
        n_errors++;
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        answer_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.offset_x    = m_tdata[CB:0];
            got.offset_y    = m_tdata[2*CB+1:CB+1];
            got.distance_q4 = m_tdata[2*CB+2+DIST_BITS-1:2*CB+2];
            if (pending_answers.size() == 0)
            begin
                report_mismatch("word with nothing pending, distance_q4",
                                longint'(got.distance_q4), longint'(0));
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.offset_x !== want.offset_x)
                    report_mismatch("offset_x", longint'(got.offset_x),
                                    longint'(want.offset_x));
                if (got.offset_y !== want.offset_y)
                    report_mismatch("offset_y", longint'(got.offset_y),
                                    longint'(want.offset_y));
                if (got.distance_q4 !== want.distance_q4)
                    report_mismatch("distance_q4", longint'(got.distance_q4),
                                    longint'(want.distance_q4));
            end
            n_results++;
        end
    end

    // watchdog: any handshake or register write counts as progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles, %0d words outstanding",
                     QUIET_LIMIT, pending_answers.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // offer one query word, wait for acceptance, then maybe idle
    task automatic send_query(logic [CB-1:0] fx, logic [CB-1:0] fy,
                              logic [CB-1:0] tx, logic [CB-1:0] ty);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {ty, tx, fy, fx};
        do
            @(posedge clk);
        while (!s_tready);
        pending_answers.push_back(predict_answer(fx, fy, tx, ty));
        n_queries++;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every predicted word came back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // both size registers, written back to back while the core is empty
    task automatic set_world(int unsigned w, int unsigned h);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_WORLD_WIDTH;
        cfg_wdata <= w[SIZE_BITS-1:0];
        @(posedge clk);
        world_w = w[SIZE_BITS-1:0];
        cfg_addr  <= REG_WORLD_HEIGHT;
        cfg_wdata <= h[SIZE_BITS-1:0];
        @(posedge clk);
        world_h = h[SIZE_BITS-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
        n_worlds++;
    endtask

    task automatic send_random_in_world(int unsigned count);
        for (int i = 0; i < count; i++)
            send_query(rand_coord(world_w), rand_coord(world_h),
                       rand_coord(world_w), rand_coord(world_h));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset-size world: corners, exact half-way ties, one past half, bit patterns
    task automatic test_reset_world();
        send_query(12'd0, 12'd0, 12'd0, 12'd0);
        send_query(12'd4095, 12'd4095, 12'd0, 12'd0);
        send_query(12'd0, 12'd0, 12'd4095, 12'd4095);
        send_query(12'd0, 12'd0, 12'd2048, 12'd2048);       // tie, stays positive
        send_query(12'd2048, 12'd2048, 12'd0, 12'd0);       // tie, stays negative
        send_query(12'd0, 12'd0, 12'd2049, 12'd2047);       // x wraps, y does not
        send_query(12'hAAA, 12'h555, 12'h555, 12'hAAA);
        send_query(12'd100, 12'd3000, 12'd3000, 12'd100);
    endtask

    // size extremes: one, zero, register maximum (distance saturates), odd sizes
    task automatic test_size_extremes();
        set_world(1, 1);
        send_query(12'd0, 12'd0, 12'd0, 12'd0);
        send_query(12'd5, 12'd0, 12'd0, 12'd7);             // coordinates past the size
        set_world(0, 0);
        send_query(12'd0, 12'd0, 12'd3, 12'd0);
        send_query(12'd3, 12'd0, 12'd0, 12'd1);
        set_world(8191, 8191);
        send_query(12'd0, 12'd0, 12'd4095, 12'd4095);       // saturates at 65535
        send_query(12'd4095, 12'd4095, 12'd0, 12'd0);
        set_world(4095, 7);
        send_query(12'd0, 12'd0, 12'd2047, 12'd3);
        send_query(12'd0, 12'd0, 12'd2048, 12'd4);
        send_query(12'd4095, 12'd0, 12'd0, 12'd6);
        set_world(2, 4096);
        send_query(12'd1, 12'd4095, 12'd0, 12'd0);
    endtask

    // valid coordinates under a range of world sizes
    task automatic test_random_worlds();
        set_world(4096, 4096);
        send_random_in_world(140);
        set_world(1, 4096);
        send_random_in_world(140);
        set_world(4096, 1);
        send_random_in_world(140);
        set_world(2, 3);
        send_random_in_world(140);
        for (int k = 0; k < 2; k++)
        begin
            set_world($urandom_range(1, 4096), $urandom_range(1, 4096));
            send_random_in_world(140);
        end
    endtask

    // any register value, any coordinate, including out-of-range pairs
    task automatic test_unbounded();
        for (int k = 0; k < 5; k++)
        begin
            set_world($urandom_range(0, 8191), $urandom_range(0, 8191));
            for (int i = 0; i < 30; i++)
                send_query(CB'($urandom_range(0, 4095)), CB'($urandom_range(0, 4095)),
                           CB'($urandom_range(0, 4095)), CB'($urandom_range(0, 4095)));
        end
    endtask

    // receiver holds off long enough for the pipe to fill and stall the input
    task automatic test_output_stall();
        set_world(4096, 4096);
        src_idle_en = 1'b0;
        hold_req = 1'b1;
        send_random_in_world(60);
        src_idle_en = 1'b1;
    endtask

    // back to back words with no idling on either side
    task automatic test_full_rate();
        set_world($urandom_range(1, 4096), $urandom_range(1, 4096));
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_random_in_world(150);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_world();
        test_size_extremes();
        test_random_worlds();
        test_unbounded();
        test_output_stall();
        test_full_rate();

        drain();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Covered %0d queries over %0d world sizes (zero, one, odd, 4096, 8191),",
                 n_queries, n_worlds);
        $display("half-way ties, saturation, a long output stall and full-rate streaming.");
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
